FILE: hdl/lzc_pkg.sv
// Shared types and constants for the LoG zero-crossing detector.
`default_nettype none

package lzc_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } t_cfg_idx;

    // Register field widths
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int THR_W        = 15;

    // Reset values
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;
    localparam int THR_RST    = 256;

    // Geometry limits
    localparam int MIN_DIM    = 3;
    localparam int HEIGHT_CAP = 4096;
    localparam int ROW_W      = 12;

    // Per-pixel tag carried alongside the sample
    typedef struct packed {
        logic             has_res;
        logic             last;
        logic [ROW_W-1:0] row;
    } t_tag;

endpackage

`default_nettype wire

FILE: hdl/lzc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [DATA_W-1:0]        i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/lzc_scan.sv
// Geometry and threshold registers plus the raster position counters.
`default_nettype none

module lzc_scan #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [lzc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [lzc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_adv,
    output logic      [$clog2(MAX_WIDTH)-1:0]       o_col,
    output logic      [$clog2(MAX_WIDTH)-1:0]       o_center_col,
    output lzc_pkg::t_tag                           o_tag,
    output logic      [lzc_pkg::THR_W-1:0]          o_thr
);

    import lzc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int W_RST_EFF = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

    logic [CW-1:0]    r_w_last;
    logic [ROW_W-1:0] r_h_last;
    logic [THR_W-1:0] r_thr;
    logic [CW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [31:0]      n_weff;
    logic [31:0]      n_heff;
    logic             end_col;
    logic             end_row;

    // Clamp incoming geometry to its legal range
    always_comb begin
        n_weff = {{(32-WIDTH_REG_W){1'b0}}, i_cfg_data[WIDTH_REG_W-1:0]};
        if (n_weff < 32'(MIN_DIM)) begin
            n_weff = 32'(MIN_DIM);
        end
        if (n_weff > 32'(MAX_WIDTH)) begin
            n_weff = 32'(MAX_WIDTH);
        end
        n_heff = {{(32-HEIGHT_REG_W){1'b0}}, i_cfg_data[HEIGHT_REG_W-1:0]};
        if (n_heff < 32'(MIN_DIM)) begin
            n_heff = 32'(MIN_DIM);
        end
        if (n_heff > 32'(HEIGHT_CAP)) begin
            n_heff = 32'(HEIGHT_CAP);
        end
    end

    assign end_col = (r_col == r_w_last);
    assign end_row = (r_row == r_h_last);

    // Config registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_last <= CW'(W_RST_EFF - 1);
            r_h_last <= ROW_W'(HEIGHT_RST - 1);
            r_thr    <= THR_W'(THR_RST);
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMAGE_WIDTH: begin
                    r_w_last <= CW'(n_weff - 32'd1);
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    r_h_last <= ROW_W'(n_heff - 32'd1);
                    r_col    <= '0;
                    r_row    <= '0;
                end
                CFG_THRESHOLD: begin
                    r_thr <= i_cfg_data[THR_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (i_adv) begin
            if (end_col) begin
                r_col <= '0;
                r_row <= end_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    // Tag for the sample at the current position
    always_comb begin
        o_tag.has_res = (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
        o_tag.last    = end_col && end_row;
        o_tag.row     = r_row - 1'b1;
    end

    assign o_col        = r_col;
    assign o_center_col = r_col - 1'b1;
    assign o_thr        = r_thr;

endmodule

`default_nettype wire

FILE: hdl/lzc_window.sv
// 3x3 window kept as per-column min/max, with the threshold decision.
`default_nettype none

module lzc_window #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_load,
    input  wire logic                            i_shift,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_top,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_mid,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_bot,
    input  wire logic        [lzc_pkg::THR_W-1:0] i_thr,
    output logic                                 o_edge
);

    import lzc_pkg::*;

    localparam int SB   = SAMPLE_BITS;
    localparam int CMPW = ((SB > THR_W) ? SB : THR_W + 1) + 1;

    logic signed [SB-1:0]   n_cmin;
    logic signed [SB-1:0]   n_cmax;
    logic signed [SB-1:0]   r_cmin;
    logic signed [SB-1:0]   r_cmax;
    logic signed [SB-1:0]   r_min1;
    logic signed [SB-1:0]   r_max1;
    logic signed [SB-1:0]   r_min2;
    logic signed [SB-1:0]   r_max2;
    logic signed [SB-1:0]   lo;
    logic signed [SB-1:0]   hi;
    logic signed [CMPW-1:0] lo_x;
    logic signed [CMPW-1:0] hi_x;
    logic signed [CMPW-1:0] thr_x;

    // Column min/max of the incoming three samples
    always_comb begin
        n_cmin = i_top;
        n_cmax = i_top;
        if (i_mid < n_cmin) begin
            n_cmin = i_mid;
        end
        if (i_mid > n_cmax) begin
            n_cmax = i_mid;
        end
        if (i_bot < n_cmin) begin
            n_cmin = i_bot;
        end
        if (i_bot > n_cmax) begin
            n_cmax = i_bot;
        end
    end

    // Current column and the two before it
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmin <= n_cmin;
            r_cmax <= n_cmax;
        end
        if (i_shift) begin
            r_min1 <= r_cmin;
            r_max1 <= r_cmax;
            r_min2 <= r_min1;
            r_max2 <= r_max1;
        end
    end

    // Window extremes against +/- threshold
    always_comb begin
        lo = r_cmin;
        hi = r_cmax;
        if (r_min1 < lo) begin
            lo = r_min1;
        end
        if (r_min2 < lo) begin
            lo = r_min2;
        end
        if (r_max1 > hi) begin
            hi = r_max1;
        end
        if (r_max2 > hi) begin
            hi = r_max2;
        end
        lo_x   = signed'({{(CMPW-SB){lo[SB-1]}}, lo});
        hi_x   = signed'({{(CMPW-SB){hi[SB-1]}}, hi});
        thr_x  = signed'({{(CMPW-THR_W){1'b0}}, i_thr});
        o_edge = (lo_x < -thr_x) && (hi_x > thr_x);
    end

endmodule

`default_nettype wire

FILE: hdl/log_zero_crossing_detector.sv
// Top level of the LoG zero-crossing detector.
//
// Takes one signed LoG sample per request in raster order and returns one
// request per interior pixel (column and row both away from the border),
// carrying the edge flag, the centre position and an end-of-image mark;
// border pixels produce nothing. One sample is taken every clock while
// o_stall is low. Each sample passes through stage 1, during the registered
// read of the single line-store memory (which holds both previous rows side
// by side, read and rewritten once per pixel), then the window stage and
// the output register. The line store needs no clearing pass after reset.
// Geometry writes restart the frame; the threshold takes effect at once.
`default_nettype none

module log_zero_crossing_detector #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [lzc_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [lzc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // sample channel
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_sample,
    // result channel
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic                                     o_edge_res,
    output logic      [$clog2(MAX_WIDTH)-1:0]        o_center_col,
    output logic      [lzc_pkg::ROW_W-1:0]           o_center_row,
    output logic                                     o_last
);

    import lzc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int SB = SAMPLE_BITS;

    logic                 en_out;
    logic                 en2;
    logic                 en1;
    logic                 accept;
    logic                 load2;
    logic                 leave2;
    logic [CW-1:0]        scan_col;
    logic [CW-1:0]        scan_ccol;
    t_tag                 scan_tag;
    logic [THR_W-1:0]     thr;
    logic [2*SB-1:0]      rd_lines;
    logic signed [SB-1:0] top;
    logic signed [SB-1:0] mid;
    logic                 win_edge;

    // stage 1: sample in flight while the line store is read
    logic                 r_v1;
    t_tag                 r_tag1;
    logic [CW-1:0]        r_col1;
    logic [CW-1:0]        r_ccol1;
    logic signed [SB-1:0] r_smp1;
    // stage 2: column min/max held in the window
    logic                 r_v2;
    t_tag                 r_tag2;
    logic [CW-1:0]        r_ccol2;
    // output register
    logic                 r_ov;
    logic                 r_edge;
    logic [CW-1:0]        r_ocol;
    logic [ROW_W-1:0]     r_orow;
    logic                 r_olast;

    // Flow control: a stage moves when the next one is empty or moving
    assign en_out  = !r_ov || !i_stall;
    assign en2     = !r_v2 || en_out;
    assign en1     = !r_v1 || en2;
    assign accept  = i_valid && en1;
    assign load2   = r_v1 && en2;
    assign leave2  = r_v2 && en_out;
    assign o_stall = !en1;

    lzc_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_adv        (accept),
        .o_col        (scan_col),
        .o_center_col (scan_ccol),
        .o_tag        (scan_tag),
        .o_thr        (thr)
    );

    // Both previous rows in one store: {older, newer}
    lzc_ram #(
        .DATA_W (2*SB),
        .DEPTH  (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (load2),
        .i_waddr (r_col1),
        .i_wdata ({mid, r_smp1}),
        .i_re    (accept),
        .i_raddr (scan_col),
        .o_rdata (rd_lines)
    );

    assign top = rd_lines[2*SB-1:SB];
    assign mid = rd_lines[SB-1:0];

    lzc_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk   (i_clk),
        .i_load  (load2),
        .i_shift (leave2),
        .i_top   (top),
        .i_mid   (mid),
        .i_bot   (r_smp1),
        .i_thr   (thr),
        .o_edge  (win_edge)
    );

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en_out) begin
                r_ov <= r_v2 && r_tag2.has_res;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag1  <= scan_tag;
            r_col1  <= scan_col;
            r_ccol1 <= scan_ccol;
            r_smp1  <= i_sample;
        end
        if (load2) begin
            r_tag2  <= r_tag1;
            r_ccol2 <= r_ccol1;
        end
        if (leave2) begin
            r_edge  <= win_edge;
            r_ocol  <= r_ccol2;
            r_orow  <= r_tag2.row;
            r_olast <= r_tag2.last;
        end
    end

    assign o_valid      = r_ov;
    assign o_edge_res   = r_edge;
    assign o_center_col = r_ocol;
    assign o_center_row = r_orow;
    assign o_last       = r_olast;

endmodule

`default_nettype wire

FILE: hdl/lzc_checker.sv
// Port-level checks for the LoG zero-crossing detector, bound to the top.
`default_nettype none

module lzc_checker #(
    parameter int MAX_WIDTH   = 2048,
    parameter int SAMPLE_BITS = 16
) (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               i_cfg_we,
    input wire logic [lzc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input wire logic                               i_valid,
    input wire logic                               o_stall,
    input wire logic signed [SAMPLE_BITS-1:0]      i_sample,
    input wire logic                               o_valid,
    input wire logic                               i_stall,
    input wire logic                               o_edge_res,
    input wire logic [$clog2(MAX_WIDTH)-1:0]       o_center_col,
    input wire logic [lzc_pkg::ROW_W-1:0]          o_center_row,
    input wire logic                               o_last
);

    import lzc_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic r_after_last;

    // Set once a final request is taken, or the frame restarts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (i_cfg_we && (i_cfg_idx == CFG_IMAGE_WIDTH
                                  || i_cfg_idx == CFG_IMAGE_HEIGHT)) begin
            r_after_last <= 1'b1;
        end else if (o_valid && !i_stall) begin
            r_after_last <= o_last;
        end
    end

    // Nothing comes out straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // A stalled sample request stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid && $stable(i_sample))
        else $error("stalled sample changed");

    // A stalled result keeps its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_edge_res)
            && $stable(o_center_col) && $stable(o_center_row) && $stable(o_last))
        else $error("stalled result changed");

    // Only interior centres are reported
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_center_col != CW'(0) && o_center_row != ROW_W'(0))
        else $error("border pixel reported");

    // A new image opens at the first interior pixel
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_after_last |-> o_center_col == CW'(1)
            && o_center_row == ROW_W'(1))
        else $error("image did not start at first interior pixel");

endmodule

bind log_zero_crossing_detector lzc_checker #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_lzc_checker (.*);

`default_nettype wire
